### hdl/cbg_pkg.sv
package cbg_pkg;

    localparam int MAX_WEIGHTS_DEF = 8;
    localparam int MAX_FREQS_DEF   = 8;

    localparam int COORD_W  = 16;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int CNT_W    = 4;
    localparam int PHASE_W  = 24;
    localparam int VALUE_W  = 16;
    localparam int INDEX_W  = 6;
    localparam int P_W      = 16;
    localparam int Q16_W    = 17;
    localparam int BLEND_W  = 35;
    localparam int BLO_W    = 17;
    localparam int PROD_W   = 48;
    localparam int T_W      = 32;
    localparam int Z_W      = 31;
    localparam int QTR_W    = 14;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 4;

    localparam int QUEUE_DEPTH   = 2;
    localparam int HORNER_STEPS  = 4;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_ALPHA = 2'd0;
    localparam logic [1:0] REG_FREQ  = 2'd1;
    localparam logic [1:0] REG_PHASE = 2'd2;

    localparam logic [CNT_W-1:0]   ALPHA_RST = 4'd4;
    localparam logic [CNT_W-1:0]   FREQ_RST  = 4'd4;
    localparam logic [PHASE_W-1:0] PHASE_RST = 24'd1048576;

    localparam logic [Q16_W-1:0]    Q16_ONE    = 17'h10000;
    localparam logic [PROD_W-1:0]   TURN_ROUND = 48'h0000_8000_0000;
    localparam logic signed [T_W-1:0] COEF_D   = 32'sd987048;
    localparam logic [VALUE_W-1:0]  VALUE_MAX  = 16'h7FFF;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] basis_value;
        logic [INDEX_W-1:0]        basis_index;
        logic                      last;
    } t_out_item;

    // one point, classified and ready for the back end
    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [DIFF_W-1:0]  diff;
        logic [CNT_W-1:0]          na;
        logic [CNT_W-1:0]          nf;
    } t_job;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               last;
    } t_tag;

    typedef struct packed {
        logic           vld;
        logic [P_W-1:0] p;
        t_tag           tag;
    } t_phase;

    // round(65536 / k)
    function automatic logic [Q16_W-1:0] recip_q16(input logic [2:0] k);
        logic [Q16_W-1:0] r;
        case (k)
            3'd1:    r = 17'd65536;
            3'd2:    r = 17'd32768;
            3'd3:    r = 17'd21845;
            3'd4:    r = 17'd16384;
            3'd5:    r = 17'd13107;
            3'd6:    r = 17'd10923;
            3'd7:    r = 17'd9362;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    // Horner coefficients in Q30, applied after the innermost term
    function automatic logic signed [T_W-1:0] horner_coef(input logic [1:0] k);
        logic signed [T_W-1:0] c;
        case (k)
            2'd0:    c = 32'sd22401992;
            2'd1:    c = 32'sd272375560;
            2'd2:    c = 32'sd1324675879;
            default: c = 32'sd1073741824;
        endcase
        return c;
    endfunction

endpackage

### hdl/cbg_front.sv
module cbg_front
    import cbg_pkg::*;
#(
    parameter int MAX_WEIGHTS = MAX_WEIGHTS_DEF,
    parameter int MAX_FREQS   = MAX_FREQS_DEF
) (
    input  logic             i_in_valid,
    input  t_in_item         i_in_data,
    input  logic [CNT_W-1:0] i_alpha_count,
    input  logic [CNT_W-1:0] i_freq_count,
    input  logic             i_q_full,
    output logic             o_in_stall,
    output logic             o_push,
    output t_job             o_job
);

    logic [CNT_W-1:0] w_na;
    logic [CNT_W-1:0] w_nf;

    // clamp counts into the supported range
    always_comb begin
        if (i_alpha_count < CNT_W'(2)) begin
            w_na = CNT_W'(2);
        end else if (i_alpha_count > CNT_W'(MAX_WEIGHTS)) begin
            w_na = CNT_W'(MAX_WEIGHTS);
        end else begin
            w_na = i_alpha_count;
        end
        if (i_freq_count == '0) begin
            w_nf = CNT_W'(1);
        end else if (i_freq_count > CNT_W'(MAX_FREQS)) begin
            w_nf = CNT_W'(MAX_FREQS);
        end else begin
            w_nf = i_freq_count;
        end
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid & ~i_q_full;

    assign o_job.y    = i_in_data.y_coord;
    assign o_job.diff = {i_in_data.x_coord[COORD_W-1], i_in_data.x_coord}
                      - {i_in_data.y_coord[COORD_W-1], i_in_data.y_coord};
    assign o_job.na   = w_na;
    assign o_job.nf   = w_nf;

endmodule

### hdl/cbg_queue.sv
module cbg_queue
    import cbg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_vld,
    output logic o_full,
    output t_job o_job
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    assign o_vld  = (r_cnt != '0);
    assign o_full = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_job  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

### hdl/cbg_phase.sv
module cbg_phase
    import cbg_pkg::*;
#(
    parameter int MAX_WEIGHTS = MAX_WEIGHTS_DEF,
    parameter int MAX_FREQS   = MAX_FREQS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [PHASE_W-1:0] i_phase_step,
    input  logic               i_q_vld,
    input  t_job               i_q_job,
    output logic               o_q_pop,
    output t_phase             o_phase
);

    localparam int JW = $clog2(MAX_WEIGHTS);
    localparam int FW = $clog2(MAX_FREQS + 1);
    localparam int MW = PHASE_W + FW;

    // sequencer
    logic                r_busy;
    t_job                r_job;
    logic [FW-1:0]       r_f;
    logic [JW-1:0]       r_j;
    logic [Q16_W-1:0]    r_a;
    logic [MW-1:0]       r_mult;
    logic [INDEX_W-1:0]  r_idx;

    logic [CNT_W-1:0]    w_na_m1;
    logic                w_last_j;
    logic                w_last_f;
    logic                w_issue_last;
    logic [Q16_W-1:0]    w_recip;
    logic [Q16_W-1:0]    w_a;

    // pipeline
    logic                       r0_vld;
    logic [Q16_W-1:0]           r0_a;
    logic signed [DIFF_W-1:0]   r0_diff;
    logic signed [COORD_W-1:0]  r0_y;
    logic [MW-1:0]              r0_mult;
    t_tag                       r0_tag;

    logic                       r1_vld;
    logic signed [BLEND_W-1:0]  r1_b;
    logic [MW-1:0]              r1_mult;
    t_tag                       r1_tag;

    logic                       r2_vld;
    logic [PROD_W-1:0]          r2_pl;
    logic [PROD_W-BLO_W-1:0]    r2_ph;
    t_tag                       r2_tag;

    logic                       r3_vld;
    logic [P_W-1:0]             r3_p;
    t_tag                       r3_tag;

    logic signed [BLEND_W-1:0]  w_ad;
    logic signed [BLEND_W-1:0]  w_yq;
    logic [BLO_W+MW-1:0]        w_pl;
    logic signed [BLEND_W-BLO_W+MW:0] w_ph;
    logic [PROD_W-1:0]          w_sum;

    assign w_na_m1      = r_job.na - 1'b1;
    assign w_last_j     = (CNT_W'(r_j) == w_na_m1);
    assign w_last_f     = (CNT_W'(r_f) == r_job.nf);
    assign w_issue_last = r_busy & w_last_j & w_last_f;
    assign w_recip      = recip_q16(w_na_m1[2:0]);
    assign w_a          = w_last_j ? Q16_ONE : r_a;

    // take the next point when idle, or while the current one issues its final value
    assign o_q_pop = i_en & i_q_vld & (~r_busy | w_issue_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_f    <= '0;
            r_j    <= '0;
            r_a    <= '0;
            r_mult <= '0;
            r_idx  <= '0;
        end else if (i_en) begin
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_f    <= FW'(1);
                r_j    <= '0;
                r_a    <= '0;
                r_mult <= MW'(i_phase_step);
                r_idx  <= '0;
            end else if (w_issue_last) begin
                r_busy <= 1'b0;
            end else if (r_busy) begin
                r_idx <= r_idx + 1'b1;
                if (w_last_j) begin
                    r_j    <= '0;
                    r_a    <= '0;
                    r_f    <= r_f + 1'b1;
                    r_mult <= r_mult + MW'(i_phase_step);
                end else begin
                    r_j <= r_j + 1'b1;
                    r_a <= r_a + w_recip;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && o_q_pop) begin
            r_job <= i_q_job;
        end
    end

    // blend: y*2^16 + a*(x - y)
    assign w_ad = $signed({1'b0, r0_a}) * r0_diff;
    assign w_yq = {{(BLEND_W-COORD_W-16){r0_y[COORD_W-1]}}, r0_y, 16'h0000};

    // phase product split in two partial products, low 48 bits kept
    assign w_pl = r1_b[BLO_W-1:0] * r1_mult;
    assign w_ph = $signed(r1_b[BLEND_W-1:BLO_W]) * $signed({1'b0, r1_mult});

    assign w_sum = {r2_ph, {BLO_W{1'b0}}} + r2_pl + TURN_ROUND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r0_vld <= r_busy;
            r1_vld <= r0_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_a         <= w_a;
            r0_diff      <= r_job.diff;
            r0_y         <= r_job.y;
            r0_mult      <= r_mult;
            r0_tag.index <= r_idx;
            r0_tag.last  <= w_issue_last;

            r1_b    <= w_yq + w_ad;
            r1_mult <= r0_mult;
            r1_tag  <= r0_tag;

            r2_pl  <= PROD_W'(w_pl);
            r2_ph  <= w_ph[PROD_W-BLO_W-1:0];
            r2_tag <= r1_tag;

            r3_p   <= w_sum[PROD_W-1:PROD_W-P_W];
            r3_tag <= r2_tag;
        end
    end

    assign o_phase.vld = r3_vld;
    assign o_phase.p   = r3_p;
    assign o_phase.tag = r3_tag;

    a_freq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_f != '0) && (CNT_W'(r_f) <= r_job.nf))
        else $error("frequency counter out of range");

    a_index_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_idx == INDEX_W'((int'(r_f) - 1) * int'(r_job.na) + int'(r_j)))
        else $error("column index out of step with counters");

    a_weight_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !w_last_j) |-> r_a == Q16_W'(int'(r_j) * int'(w_recip)))
        else $error("weight accumulator out of step");

    a_pop_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_busy && r_idx == '0 && r_j == '0)
        else $error("point load did not restart the sequence");

    a_last_then_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r0_vld && r0_tag.last) |=> (!r0_vld || r0_tag.index == '0))
        else $error("value issued after last without a new point");

endmodule

### hdl/cbg_cos.sv
module cbg_cos
    import cbg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_phase    i_phase,
    input  logic      i_out_stall,
    output logic      o_en,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    logic                      r_c0_vld;
    logic [Z_W-1:0]            r_c0_z;
    logic                      r_c0_neg;
    t_tag                      r_c0_tag;

    logic                      r_hv   [HORNER_STEPS];
    logic signed [T_W-1:0]     r_ht   [HORNER_STEPS];
    logic [Z_W-1:0]            r_hz   [HORNER_STEPS];
    logic                      r_hn   [HORNER_STEPS];
    t_tag                      r_htag [HORNER_STEPS];

    logic                      r_out_vld;
    t_out_item                 r_out;

    logic [1:0]                w_q;
    logic [QTR_W:0]            w_u;
    logic [2*QTR_W+1:0]        w_uu;

    logic signed [T_W-1:0]     w_tin  [HORNER_STEPS];
    logic [Z_W-1:0]            w_zin  [HORNER_STEPS];
    logic signed [2*T_W-1:0]   w_prod [HORNER_STEPS];

    logic signed [T_W-1:0]     w_t;
    logic [T_W-1:0]            w_tc;
    logic [T_W-1:0]            w_rnd;
    logic [VALUE_W-1:0]        w_sat;
    logic [VALUE_W-1:0]        w_val;

    // whole pipeline advances when the output register can take a value
    assign o_en = ~r_out_vld | ~i_out_stall;

    // fold the turn into the first quadrant
    assign w_q  = i_phase.p[P_W-1:P_W-2];
    assign w_u  = w_q[0] ? ((QTR_W+1)'(1 << QTR_W) - {1'b0, i_phase.p[QTR_W-1:0]})
                         : {1'b0, i_phase.p[QTR_W-1:0]};
    assign w_uu = w_u * w_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0_vld <= 1'b0;
        end else if (o_en) begin
            r_c0_vld <= i_phase.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_c0_z   <= {w_uu[Z_W-3:0], 2'b00};
            r_c0_neg <= w_q[1] ^ w_q[0];
            r_c0_tag <= i_phase.tag;
        end
    end

    for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_horner
        if (k == 0) begin : g_first
            assign w_tin[k] = COEF_D;
            assign w_zin[k] = r_c0_z;
        end else begin : g_next
            assign w_tin[k] = r_ht[k-1];
            assign w_zin[k] = r_hz[k-1];
        end

        assign w_prod[k] = w_tin[k] * $signed({1'b0, w_zin[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_hv[k] <= 1'b0;
            end else if (o_en) begin
                r_hv[k] <= (k == 0) ? r_c0_vld : r_hv[(k == 0) ? 0 : k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (o_en) begin
                r_ht[k]   <= horner_coef(2'(k)) - w_prod[k][T_W+29:30];
                r_hz[k]   <= w_zin[k];
                r_hn[k]   <= (k == 0) ? r_c0_neg : r_hn[(k == 0) ? 0 : k-1];
                r_htag[k] <= (k == 0) ? r_c0_tag : r_htag[(k == 0) ? 0 : k-1];
            end
        end
    end

    // clamp, round to Q15, saturate, apply quadrant sign
    assign w_t   = r_ht[HORNER_STEPS-1];
    assign w_tc  = w_t[T_W-1] ? '0 : w_t;
    assign w_rnd = (w_tc + T_W'(1 << 14)) >> 15;
    assign w_sat = (w_rnd > T_W'(VALUE_MAX)) ? VALUE_MAX : w_rnd[VALUE_W-1:0];
    assign w_val = r_hn[HORNER_STEPS-1] ? (~w_sat + 1'b1) : w_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_en) begin
            r_out_vld <= r_hv[HORNER_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_out.basis_value <= w_val;
            r_out.basis_index <= r_htag[HORNER_STEPS-1].index;
            r_out.last        <= r_htag[HORNER_STEPS-1].last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

### hdl/cosine_basis_generator_core.sv
// Cosine basis generator. Each accepted point (x_coord, y_coord, signed Q8.8) yields
// alpha_count * freq_count values cos(f * phase_step * (a*x + (1-a)*y)) in Q1.15,
// frequency-major, with basis_index = (f-1)*alpha_count + j and last set on the final
// value of the point; a point yields 2 to 64 values. The sequencer issues one value
// per clock while the output is not stalled, and consecutive points follow without a
// gap; a two-point queue sits in front of it. A value passes four phase stages, five
// cosine stages and the output register on its way to the output. Output stall
// freezes the whole back-end pipeline. Program the registers over APB only while no
// point is in flight.
module cosine_basis_generator_core
    import cbg_pkg::*;
#(
    parameter int MAX_WEIGHTS = MAX_WEIGHTS_DEF,
    parameter int MAX_FREQS   = MAX_FREQS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              i_in_valid,
    input  t_in_item          i_in_data,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output t_out_item         o_out_data,
    input  logic              i_out_stall
);

    logic [CNT_W-1:0]   r_alpha_count;
    logic [CNT_W-1:0]   r_freq_count;
    logic [PHASE_W-1:0] r_phase_step;

    logic               w_wr;
    logic [1:0]         w_reg;

    logic               w_push;
    logic               w_pop;
    logic               w_q_vld;
    logic               w_q_full;
    t_job               w_job_in;
    t_job               w_job_out;
    t_phase             w_phase;
    logic               w_en;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_reg  = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_count <= ALPHA_RST;
            r_freq_count  <= FREQ_RST;
            r_phase_step  <= PHASE_RST;
        end else if (w_wr) begin
            case (w_reg)
                REG_ALPHA: r_alpha_count <= pwdata[CNT_W-1:0];
                REG_FREQ:  r_freq_count  <= pwdata[CNT_W-1:0];
                REG_PHASE: r_phase_step  <= pwdata[PHASE_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_ALPHA: prdata = DATA_W'(r_alpha_count);
            REG_FREQ:  prdata = DATA_W'(r_freq_count);
            REG_PHASE: prdata = DATA_W'(r_phase_step);
            default:   prdata = '0;
        endcase
    end

    cbg_front #(
        .MAX_WEIGHTS (MAX_WEIGHTS),
        .MAX_FREQS   (MAX_FREQS)
    ) u_front (
        .i_in_valid    (i_in_valid),
        .i_in_data     (i_in_data),
        .i_alpha_count (r_alpha_count),
        .i_freq_count  (r_freq_count),
        .i_q_full      (w_q_full),
        .o_in_stall    (o_in_stall),
        .o_push        (w_push),
        .o_job         (w_job_in)
    );

    cbg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_vld   (w_q_vld),
        .o_full  (w_q_full),
        .o_job   (w_job_out)
    );

    cbg_phase #(
        .MAX_WEIGHTS (MAX_WEIGHTS),
        .MAX_FREQS   (MAX_FREQS)
    ) u_phase (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_phase_step (r_phase_step),
        .i_q_vld      (w_q_vld),
        .i_q_job      (w_job_out),
        .o_q_pop      (w_pop),
        .o_phase      (w_phase)
    );

    cbg_cos u_cos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_phase     (w_phase),
        .i_out_stall (i_out_stall),
        .o_en        (w_en),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
